@@ rtl/ibs_pkg.sv @@
// Shared types and constants for the icon list best size selector.
// Used by the controller, datapath, divider, top level and checker.
// No dependencies.
`default_nettype none

package ibs_pkg;

    // Field widths
    localparam int WORD_W    = 32;
    localparam int DIM_W     = 14;
    localparam int TGT_W     = 13;
    localparam int OFF_W     = 24;
    localparam int STAT_W    = 2;
    localparam int PIX_W     = 2 * DIM_W;

    // Stream length limit and word counter (saturates at MAX_WORDS)
    localparam int MAX_WORDS = 16777216;
    localparam int CNT_W     = $clog2(MAX_WORDS) + 1;

    // Scaling divider: small side * target / large side
    localparam int NUM_W     = DIM_W + TGT_W;
    localparam int DCNT_W    = $clog2(NUM_W + 1);

    localparam int TGT_RESET = 16;

    // Result beat layout, lowest bit first
    localparam int OUT_FIELDS_W = STAT_W + 2 * DIM_W + OFF_W + 2 * TGT_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Result status; as an error register STAT_FOUND means "no error yet"
    typedef enum logic [1:0] {
        STAT_FOUND    = 2'd0,
        STAT_NONE     = 2'd1,
        STAT_OVERSIZE = 2'd2,
        STAT_TOO_LONG = 2'd3
    } status_t;

    // Position inside one icon record
    typedef enum logic [1:0] {
        PH_WIDTH,
        PH_HEIGHT,
        PH_PIXELS
    } phase_t;

    // Controller states
    typedef enum logic [2:0] {
        FSM_RUN,
        FSM_PICK,
        FSM_MUL,
        FSM_DIVGO,
        FSM_DIV,
        FSM_OUT
    } fsm_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // input beats may be taken
        logic pick;       // latch the choice, clear the stream state
        logic mul;        // register small side * target
        logic div_start;  // launch the scaling division
        logic load_out;   // move the result into the output register
    } ibs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic found;      // current choice is a usable icon
        logic div_busy;
        logic out_free;   // output register can take a result
    } ibs_sts_t;

endpackage

`default_nettype wire

@@ rtl/ibs_div.sv @@
// Restoring divider, one quotient bit per cycle, for the aspect scaling.
// Depends on ibs_pkg.
`default_nettype none

module ibs_div
    import ibs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DIM_W-1:0]  den,
    output logic                   busy,
    output logic [NUM_W-1:0]       quo
);

    logic [NUM_W-1:0]  nq_reg,   nq_next;   // dividend shifts out, quotient in
    logic [DIM_W-1:0]  rem_reg,  rem_next;
    logic [DIM_W-1:0]  den_reg,  den_next;
    logic [DCNT_W-1:0] cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;

    logic [DIM_W:0]    rem_sh;
    logic [DIM_W:0]    rem_sub;
    logic              q_bit;

    // One restoring step
    always_comb begin
        rem_sh  = {rem_reg, nq_reg[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        q_bit   = (rem_sh >= {1'b0, den_reg});

        nq_next   = nq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            nq_next   = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = DCNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            nq_next  = {nq_reg[NUM_W-2:0], q_bit};
            rem_next = q_bit ? rem_sub[DIM_W-1:0] : rem_sh[DIM_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quo  = nq_reg;

endmodule

`default_nettype wire

@@ rtl/ibs_ctrl.sv @@
// Controller state machine: streams words, then sequences pick, scale (only when an icon is found), output.
// Depends on ibs_pkg.
`default_nettype none

module ibs_ctrl
    import ibs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    input  wire logic     s_tlast,
    input  wire ibs_sts_t sts,
    output ibs_cmd_t      cmd
);

    fsm_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            FSM_RUN: begin
                cmd.accept = 1'b1;
                if (s_tvalid && s_tlast) begin
                    state_next = FSM_PICK;
                end
            end
            FSM_PICK: begin
                cmd.pick   = 1'b1;
                state_next = sts.found ? FSM_MUL : FSM_OUT;
            end
            FSM_MUL: begin
                cmd.mul    = 1'b1;
                state_next = FSM_DIVGO;
            end
            FSM_DIVGO: begin
                cmd.div_start = 1'b1;
                state_next    = FSM_DIV;
            end
            FSM_DIV: begin
                if (!sts.div_busy) begin
                    state_next = FSM_OUT;
                end
            end
            FSM_OUT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = FSM_RUN;
                end
            end
            default: begin
                state_next = FSM_RUN;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/ibs_datapath.sv @@
// Datapath: icon header parsing, ranking, choice, scale product, output register.
// Depends on ibs_pkg; works with ibs_div for the scaled side.
`default_nettype none

module ibs_datapath
    import ibs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ibs_cmd_t          cmd,
    output ibs_sts_t               sts,
    input  wire logic              cfg_we,
    input  wire logic [TGT_W-1:0]  cfg_wdata,
    input  wire logic              s_tvalid,
    input  wire logic [WORD_W-1:0] s_word,
    output logic [NUM_W-1:0]       div_num,
    output logic [DIM_W-1:0]       div_den,
    input  wire logic              div_busy,
    input  wire logic [NUM_W-1:0]  div_quo,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata
);

    // Configuration
    logic [TGT_W-1:0] target_reg;

    // Stream state
    phase_t           phase_reg,     phase_next;
    logic             w_big_reg,     w_big_next;
    logic [DIM_W-1:0] hdr_w_reg,     hdr_w_next;
    logic [DIM_W-1:0] hdr_h_reg,     hdr_h_next;
    logic [PIX_W-1:0] pix_left_reg,  pix_left_next;
    logic [CNT_W-1:0] word_cnt_reg,  word_cnt_next;
    logic [OFF_W-1:0] icon_off_reg,  icon_off_next;
    status_t          err_reg,       err_next;
    logic             ab_found_reg,  ab_found_next;
    logic [DIM_W-1:0] ab_excess_reg, ab_excess_next;
    logic [DIM_W-1:0] ab_w_reg,      ab_w_next;
    logic [DIM_W-1:0] ab_h_reg,      ab_h_next;
    logic [OFF_W-1:0] ab_off_reg,    ab_off_next;
    logic             be_found_reg,  be_found_next;
    logic [TGT_W-1:0] be_short_reg,  be_short_next;
    logic [DIM_W-1:0] be_w_reg,      be_w_next;
    logic [DIM_W-1:0] be_h_reg,      be_h_next;
    logic [OFF_W-1:0] be_off_reg,    be_off_next;

    // Result being built
    status_t          res_stat_reg;
    logic [DIM_W-1:0] res_w_reg;
    logic [DIM_W-1:0] res_h_reg;
    logic [OFF_W-1:0] res_off_reg;
    logic             res_wide_reg;
    logic [DIM_W-1:0] small_reg;
    logic [DIM_W-1:0] large_reg;
    logic [NUM_W-1:0] prod_reg;

    // Output register
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    logic             beat;
    logic             cnt_full;
    logic [CNT_W-1:0] idx_plus1;
    logic [DIM_W-1:0] word_dim;
    logic             word_big;
    logic [PIX_W-1:0] pix_prod;

    logic             rank_en;
    logic [DIM_W-1:0] rank_w;
    logic [DIM_W-1:0] rank_h;
    logic [OFF_W-1:0] rank_off;
    logic [DIM_W-1:0] rank_m;
    logic [DIM_W-1:0] tgt_ext;
    logic             rank_above;
    logic [DIM_W-1:0] rank_excess;
    logic [TGT_W-1:0] rank_short;

    logic [DIM_W-1:0] ch_w;
    logic [DIM_W-1:0] ch_h;
    logic [OFF_W-1:0] ch_off;
    status_t          pick_stat;

    logic [TGT_W-1:0] quo_side;
    logic [TGT_W-1:0] sc_w;
    logic [TGT_W-1:0] sc_h;

    assign beat      = s_tvalid && cmd.accept;
    assign cnt_full  = (word_cnt_reg >= CNT_W'(MAX_WORDS));
    assign idx_plus1 = word_cnt_reg + 1'b1;
    assign word_dim  = s_word[DIM_W-1:0];
    assign word_big  = |s_word[WORD_W-1:DIM_W];
    assign pix_prod  = PIX_W'(hdr_w_reg) * PIX_W'(word_dim);
    assign tgt_ext   = DIM_W'(target_reg);

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= TGT_W'(TGT_RESET);
        end else if (cfg_we) begin
            target_reg <= cfg_wdata;
        end
    end

    // Header parsing and pixel countdown
    always_comb begin
        phase_next    = phase_reg;
        w_big_next    = w_big_reg;
        hdr_w_next    = hdr_w_reg;
        hdr_h_next    = hdr_h_reg;
        pix_left_next = pix_left_reg;
        word_cnt_next = word_cnt_reg;
        icon_off_next = icon_off_reg;
        err_next      = err_reg;
        rank_en       = 1'b0;
        rank_w        = hdr_w_reg;
        rank_h        = hdr_h_reg;
        rank_off      = icon_off_reg;

        if (beat) begin
            if (cnt_full) begin
                if (err_reg == STAT_FOUND) begin
                    err_next = STAT_TOO_LONG;
                end
            end else begin
                word_cnt_next = idx_plus1;
                if (err_reg == STAT_FOUND) begin
                    unique case (phase_reg)
                        PH_WIDTH: begin
                            hdr_w_next = word_dim;
                            w_big_next = word_big;
                            phase_next = PH_HEIGHT;
                        end
                        PH_HEIGHT: begin
                            if (w_big_reg || word_big) begin
                                err_next   = STAT_OVERSIZE;
                                phase_next = PH_WIDTH;
                            end else begin
                                hdr_h_next    = word_dim;
                                pix_left_next = pix_prod;
                                icon_off_next = idx_plus1[OFF_W-1:0];
                                // Empty icon: ranked at once
                                if (hdr_w_reg == '0 || word_dim == '0) begin
                                    rank_en    = 1'b1;
                                    rank_h     = word_dim;
                                    rank_off   = idx_plus1[OFF_W-1:0];
                                    phase_next = PH_WIDTH;
                                end else begin
                                    phase_next = PH_PIXELS;
                                end
                            end
                        end
                        PH_PIXELS: begin
                            pix_left_next = pix_left_reg - 1'b1;
                            if (pix_left_reg == PIX_W'(1)) begin
                                rank_en    = 1'b1;
                                phase_next = PH_WIDTH;
                            end
                        end
                        default: begin
                            phase_next = PH_WIDTH;
                        end
                    endcase
                end
            end
        end
    end

    // Ranking of a complete icon
    always_comb begin
        rank_m      = (rank_w > rank_h) ? rank_w : rank_h;
        rank_above  = (rank_m >= tgt_ext);
        rank_excess = rank_m - tgt_ext;
        rank_short  = target_reg - rank_m[TGT_W-1:0];

        ab_found_next  = ab_found_reg;
        ab_excess_next = ab_excess_reg;
        ab_w_next      = ab_w_reg;
        ab_h_next      = ab_h_reg;
        ab_off_next    = ab_off_reg;
        be_found_next  = be_found_reg;
        be_short_next  = be_short_reg;
        be_w_next      = be_w_reg;
        be_h_next      = be_h_reg;
        be_off_next    = be_off_reg;

        if (rank_en) begin
            if (rank_above) begin
                if (!ab_found_reg || rank_excess < ab_excess_reg) begin
                    ab_found_next  = 1'b1;
                    ab_excess_next = rank_excess;
                    ab_w_next      = rank_w;
                    ab_h_next      = rank_h;
                    ab_off_next    = rank_off;
                end
            end else begin
                if (!be_found_reg || rank_short < be_short_reg) begin
                    be_found_next = 1'b1;
                    be_short_next = rank_short;
                    be_w_next     = rank_w;
                    be_h_next     = rank_h;
                    be_off_next   = rank_off;
                end
            end
        end
    end

    // Stream state registers; a pick starts a fresh property
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.pick) begin
            phase_reg     <= PH_WIDTH;
            w_big_reg     <= 1'b0;
            hdr_w_reg     <= '0;
            hdr_h_reg     <= '0;
            pix_left_reg  <= '0;
            word_cnt_reg  <= '0;
            icon_off_reg  <= '0;
            err_reg       <= STAT_FOUND;
            ab_found_reg  <= 1'b0;
            ab_excess_reg <= '0;
            ab_w_reg      <= '0;
            ab_h_reg      <= '0;
            ab_off_reg    <= '0;
            be_found_reg  <= 1'b0;
            be_short_reg  <= '0;
            be_w_reg      <= '0;
            be_h_reg      <= '0;
            be_off_reg    <= '0;
        end else begin
            phase_reg     <= phase_next;
            w_big_reg     <= w_big_next;
            hdr_w_reg     <= hdr_w_next;
            hdr_h_reg     <= hdr_h_next;
            pix_left_reg  <= pix_left_next;
            word_cnt_reg  <= word_cnt_next;
            icon_off_reg  <= icon_off_next;
            err_reg       <= err_next;
            ab_found_reg  <= ab_found_next;
            ab_excess_reg <= ab_excess_next;
            ab_w_reg      <= ab_w_next;
            ab_h_reg      <= ab_h_next;
            ab_off_reg    <= ab_off_next;
            be_found_reg  <= be_found_next;
            be_short_reg  <= be_short_next;
            be_w_reg      <= be_w_next;
            be_h_reg      <= be_h_next;
            be_off_reg    <= be_off_next;
        end
    end

    // Final choice: above target wins over below target
    always_comb begin
        ch_w   = ab_found_reg ? ab_w_reg   : be_w_reg;
        ch_h   = ab_found_reg ? ab_h_reg   : be_h_reg;
        ch_off = ab_found_reg ? ab_off_reg : be_off_reg;
        if (err_reg != STAT_FOUND) begin
            pick_stat = err_reg;
        end else if ((ab_found_reg || be_found_reg) && ch_w != '0 && ch_h != '0) begin
            pick_stat = STAT_FOUND;
        end else begin
            pick_stat = STAT_NONE;
        end
    end

    // Result registers and scale product
    always_ff @(posedge aclk) begin
        if (cmd.pick) begin
            res_stat_reg <= pick_stat;
            res_wide_reg <= (ch_w > ch_h);
            small_reg    <= (ch_w > ch_h) ? ch_h : ch_w;
            large_reg    <= (ch_w > ch_h) ? ch_w : ch_h;
            if (pick_stat == STAT_FOUND) begin
                res_w_reg   <= ch_w;
                res_h_reg   <= ch_h;
                res_off_reg <= ch_off;
            end else begin
                res_w_reg   <= '0;
                res_h_reg   <= '0;
                res_off_reg <= '0;
            end
        end
        if (cmd.mul) begin
            prod_reg <= NUM_W'(small_reg) * NUM_W'(target_reg);
        end
    end

    assign div_num = prod_reg;
    assign div_den = large_reg;

    // Scaled sides: longer side takes the target, shorter at least 1
    always_comb begin
        quo_side = (div_quo[TGT_W-1:0] == '0) ? TGT_W'(1) : div_quo[TGT_W-1:0];
        sc_w     = '0;
        sc_h     = '0;
        if (res_stat_reg == STAT_FOUND) begin
            sc_w = res_wide_reg ? target_reg : quo_side;
            sc_h = res_wide_reg ? quo_side   : target_reg;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            m_tdata_reg <= OUT_W'({sc_h, sc_w, res_off_reg, res_h_reg, res_w_reg,
                                   res_stat_reg});
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;

    assign sts.found    = (pick_stat == STAT_FOUND);
    assign sts.div_busy = div_busy;
    assign sts.out_free = !m_tvalid_reg || m_tready;

endmodule

`default_nettype wire

@@ rtl/icon_list_best_size_select.sv @@
// Icon list best size selector: top level joining controller, datapath, divider.
// Depends on ibs_pkg, ibs_ctrl, ibs_datapath, ibs_div.
//
// Usage:
//   Words of an icon list property (width, height, width*height pixels, repeated)
//   enter on the s_ channel, one beat per cycle while s_tready is high; tlast
//   marks the final word. Each property gives exactly one result beat on the
//   m_ channel: status, chosen width/height, pixel word offset and the size
//   scaled to fit target_size (written through cfg_we/cfg_wdata while idle).
//   Every word is taken as soon as it is offered while s_tready is high. After the last
//   word s_tready drops while the choice is made and scaled: a pick, then the
//   load into the output register when no icon is found; when one is, a pick,
//   a multiply, the division launch, the divide wait (the quotient bits, then
//   a check that it has finished) and the load. Once the result sits in the
//   output register, s_tready rises again, so the next property streams in
//   while the result waits. If the receiver stalls with a result still held,
//   the next result waits in the controller and s_tready stays low until it
//   moves.
//   Reset (aresetn low, synchronous) empties the output, clears the stream
//   state and sets target_size to 16.
`default_nettype none

module icon_list_best_size_select
    import ibs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Configuration: target_size
    input  wire logic              cfg_we,
    input  wire logic [TGT_W-1:0]  cfg_wdata,
    // Property words
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [WORD_W-1:0] s_tdata,   // [31:0] word
    input  wire logic              s_tlast,   // last word of the property
    // Results
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata    // [1:0] status, [15:2] icon_width,
                                              // [29:16] icon_height,
                                              // [53:30] pixel_offset,
                                              // [66:54] scaled_width,
                                              // [79:67] scaled_height
);

    ibs_cmd_t         cmd;
    ibs_sts_t         sts;
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [DIM_W-1:0] div_den;
    logic             div_busy;
    logic [NUM_W-1:0] div_quo;

    assign s_tready  = cmd.accept;
    assign div_start = cmd.div_start;

    ibs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    ibs_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_word    (s_tdata),
        .div_num   (div_num),
        .div_den   (div_den),
        .div_busy  (div_busy),
        .div_quo   (div_quo),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    ibs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quo     (div_quo)
    );

endmodule

`default_nettype wire

@@ rtl/ibs_checker.sv @@
// Port-level checks for the icon list best size selector, bound to the top.
// Depends on ibs_pkg and icon_list_best_size_select.
`default_nettype none

module ibs_checker
    import ibs_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              s_tlast,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [OUT_W-1:0]  m_tdata
);

    // A stalled result beat stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // Input is closed right after the last word is taken
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input open right after last word");

    // Non-found results carry only the status
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[STAT_W-1:0] != STAT_FOUND
            |-> m_tdata[OUT_FIELDS_W-1:STAT_W] == '0)
        else $error("fields set on a result without an icon");

    // A found icon has two nonzero sides
    a_found_dims: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[STAT_W-1:0] == STAT_FOUND
            |-> m_tdata[STAT_W+DIM_W-1:STAT_W] != '0
             && m_tdata[STAT_W+2*DIM_W-1:STAT_W+DIM_W] != '0)
        else $error("found icon with a zero side");

endmodule

bind icon_list_best_size_select ibs_checker u_ibs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
